@@ sv/morse_led_keyer_top_macros.svh @@
// assertion helpers for the keyer
`ifndef MORSE_LED_KEYER_TOP_MACROS_SVH
`define MORSE_LED_KEYER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MLK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("keyer assertion failed");
`define MLK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("keyer assertion failed");
`else
`define MLK_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MLK_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/mlk_pkg.sv @@
package mlk_pkg;

  localparam int BUF_DEPTH = 20;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int CMP_W     = (IDX_W > 5) ? IDX_W : 5;
  localparam logic [IDX_W-1:0] BUF_LAST = IDX_W'(BUF_DEPTH - 1);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // register indexes
  localparam logic [2:0] REG_DOT    = 3'd0;
  localparam logic [2:0] REG_DASH   = 3'd1;
  localparam logic [2:0] REG_EGAP   = 3'd2;
  localparam logic [2:0] REG_LGAP   = 3'd3;
  localparam logic [2:0] REG_WLEN   = 3'd4;
  localparam logic [2:0] REG_FRAME  = 3'd5;

  // character classes
  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_T     = 3'd1;
  localparam logic [2:0] CLS_E     = 3'd2;
  localparam logic [2:0] CLS_S     = 3'd3;
  localparam logic [2:0] CLS_THREE = 3'd4;

  typedef struct packed {
    logic [15:0] dot_ticks;
    logic [15:0] dash_ticks;
    logic [15:0] element_gap_ticks;
    logic [15:0] letter_gap_ticks;
    logic [4:0]  word_length;
    logic [15:0] frame_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic       is_char;
    logic [2:0] cls;
  } q_item_t;

  function automatic logic [2:0] cls_len(input logic [2:0] cls);
    logic [2:0] len;
    unique case (cls)
      CLS_T, CLS_E: len = 3'd1;
      CLS_S:        len = 3'd3;
      CLS_THREE:    len = 3'd5;
      default:      len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic cls_dash(input logic [2:0] cls, input logic [2:0] eidx);
    logic d;
    unique case (cls)
      CLS_T:     d = (eidx == 3'd0);
      CLS_THREE: d = (eidx == 3'd3) || (eidx == 3'd4);
      default:   d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

@@ sv/mlk_front.sv @@
module mlk_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tuser,   // [0] req_type
  input  logic [7:0]        in_tdata,   // [7:0] char_code
  input  logic              q_full,
  output logic              q_push,
  output mlk_pkg::q_item_t  q_item
);

  logic [2:0] cls;

  always_comb begin
    unique case (in_tdata) inside
      8'h54, 8'h74: cls = mlk_pkg::CLS_T;
      8'h45, 8'h65: cls = mlk_pkg::CLS_E;
      8'h53, 8'h73: cls = mlk_pkg::CLS_S;
      8'h33:        cls = mlk_pkg::CLS_THREE;
      default:      cls = mlk_pkg::CLS_NONE;
    endcase
  end

  assign in_tready      = !q_full;
  assign q_push         = in_tvalid && !q_full;
  assign q_item.is_char = in_tuser;
  assign q_item.cls     = cls;

endmodule

@@ sv/mlk_fifo.sv @@
module mlk_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mlk_pkg::q_item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output mlk_pkg::q_item_t  q_item
);

  mlk_pkg::q_item_t            slots_r [mlk_pkg::Q_DEPTH];
  logic [mlk_pkg::QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [mlk_pkg::QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [mlk_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_pop;

  assign full    = (cnt_r == mlk_pkg::QCNT_W'(mlk_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = slots_r[rptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == mlk_pkg::QPTR_W'(mlk_pkg::Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == mlk_pkg::QPTR_W'(mlk_pkg::Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wptr_r] <= push_item;
    end
  end

endmodule

@@ sv/mlk_back.sv @@
module mlk_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mlk_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  mlk_pkg::q_item_t  q_item,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata   // [0] led_on, [1] playing, [7:2] zero
);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_PROCESS = 3'd1;
  localparam logic [2:0] MODE_ON      = 3'd2;
  localparam logic [2:0] MODE_OFF     = 3'd3;
  localparam logic [2:0] MODE_GAP     = 3'd4;

  localparam int IW = mlk_pkg::IDX_W;
  localparam int CW = mlk_pkg::CMP_W;

  logic [2:0]    mode_r, mode_nxt;
  logic [15:0]   gap_r, gap_nxt;
  logic [15:0]   frame_r, frame_nxt;
  logic [IW-1:0] wcnt_r, wcnt_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [2:0]    eidx_r, eidx_nxt;
  logic          led_r, led_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [2:0]    cls_r;

  logic [2:0]    store [mlk_pkg::BUF_DEPTH];
  logic          we;

  logic          take;
  logic [15:0]   gap_inc;
  logic [15:0]   dur;
  logic [2:0]    len;
  logic [2:0]    e_next;

  assign take    = q_valid && (!ovalid_r || out_tready);
  assign q_pop   = take;
  assign gap_inc = (gap_r != 16'hFFFF) ? gap_r + 16'd1 : gap_r;
  assign len     = mlk_pkg::cls_len(cls_r);
  assign dur     = mlk_pkg::cls_dash(cls_r, eidx_r) ? cfg.dash_ticks : cfg.dot_ticks;
  assign e_next  = eidx_r + 3'd1;

  always_comb begin
    mode_nxt   = mode_r;
    gap_nxt    = gap_r;
    frame_nxt  = frame_r;
    wcnt_nxt   = wcnt_r;
    pidx_nxt   = pidx_r;
    eidx_nxt   = eidx_r;
    led_nxt    = led_r;
    we         = 1'b0;
    ovalid_nxt = ovalid_r && !out_tready;
    if (take) begin
      ovalid_nxt = 1'b1;
      if (q_item.is_char) begin
        if (wcnt_r < mlk_pkg::BUF_LAST) begin
          we       = 1'b1;
          wcnt_nxt = wcnt_r + 1'b1;
        end
      end else begin
        if (frame_r != 16'hFFFF) begin
          frame_nxt = frame_r + 16'd1;
        end
        unique case (mode_r)
          MODE_PROCESS: begin
            if (pidx_r < wcnt_r) begin
              eidx_nxt = 3'd0;
              if (len != 3'd0) begin
                led_nxt  = 1'b1;
                gap_nxt  = 16'd0;
                mode_nxt = MODE_ON;
              end else begin
                pidx_nxt = pidx_r + 1'b1;
              end
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_ON: begin
            gap_nxt = gap_inc;
            if (gap_inc >= dur) begin
              led_nxt  = 1'b0;
              gap_nxt  = 16'd0;
              mode_nxt = MODE_OFF;
            end
          end
          MODE_OFF: begin
            gap_nxt = gap_inc;
            if (gap_inc >= cfg.element_gap_ticks) begin
              eidx_nxt = e_next;
              gap_nxt  = 16'd0;
              if (e_next < len) begin
                led_nxt  = 1'b1;
                mode_nxt = MODE_ON;
              end else begin
                pidx_nxt = pidx_r + 1'b1;
                mode_nxt = MODE_GAP;
              end
            end
          end
          MODE_GAP: begin
            gap_nxt = gap_inc;
            if (gap_inc >= cfg.letter_gap_ticks) begin
              mode_nxt = MODE_PROCESS;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
            if (frame_nxt >= cfg.frame_period_ticks) begin
              frame_nxt = 16'd0;
              wcnt_nxt  = '0;
              pidx_nxt  = '0;
            end else if (CW'(wcnt_r) >= CW'(cfg.word_length) && pidx_r == '0) begin
              mode_nxt = MODE_PROCESS;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      gap_r    <= '0;
      frame_r  <= '0;
      wcnt_r   <= '0;
      pidx_r   <= '0;
      eidx_r   <= '0;
      led_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      gap_r    <= gap_nxt;
      frame_r  <= frame_nxt;
      wcnt_r   <= wcnt_nxt;
      pidx_r   <= pidx_nxt;
      eidx_r   <= eidx_nxt;
      led_r    <= led_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // class store, read port follows the next play index, write-first on collision
  always_ff @(posedge clk) begin
    if (we) begin
      store[wcnt_r] <= q_item.cls;
    end
    if (we && wcnt_r == pidx_nxt) begin
      cls_r <= q_item.cls;
    end else begin
      cls_r <= store[pidx_nxt];
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'd0, (mode_r != MODE_IDLE), led_r};

endmodule

@@ sv/morse_led_keyer_top.sv @@
// Morse keyer for one LED. Input beats are either a millisecond tick (in_tuser = 0) or a
// received character (in_tuser = 1, byte in in_tdata); each beat yields exactly one result
// beat carrying the LED level and the playing flag. One beat per clock is accepted and
// delivered when both sides keep up; a result passes through the two-entry queue between
// the character classifier and the playback sequencer and then through the output register.
// Characters are stored as Morse classes in a 20-entry store of which 19 entries are used;
// only T, E, S and 3 are keyed, others are skipped. The user must write the timing registers
// over the APB port only while the block is idle; the block itself does not enforce this.
`include "morse_led_keyer_top_macros.svh"

module morse_led_keyer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,     // [0] req_type
  input  logic [7:0]  in_tdata,     // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [0] led_on, [1] playing, [7:2] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mlk_pkg::cfg_t     cfg_r;
  mlk_pkg::q_item_t  push_item;
  mlk_pkg::q_item_t  q_item;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  logic [2:0]        reg_idx;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_ticks          <= 16'd25;
      cfg_r.dash_ticks         <= 16'd75;
      cfg_r.element_gap_ticks  <= 16'd30;
      cfg_r.letter_gap_ticks   <= 16'd100;
      cfg_r.word_length        <= 5'd5;
      cfg_r.frame_period_ticks <= 16'd2000;
    end else if (wr_en) begin
      unique case (reg_idx)
        mlk_pkg::REG_DOT:   cfg_r.dot_ticks          <= cfg_pwdata[15:0];
        mlk_pkg::REG_DASH:  cfg_r.dash_ticks         <= cfg_pwdata[15:0];
        mlk_pkg::REG_EGAP:  cfg_r.element_gap_ticks  <= cfg_pwdata[15:0];
        mlk_pkg::REG_LGAP:  cfg_r.letter_gap_ticks   <= cfg_pwdata[15:0];
        mlk_pkg::REG_WLEN:  cfg_r.word_length        <= cfg_pwdata[4:0];
        mlk_pkg::REG_FRAME: cfg_r.frame_period_ticks <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mlk_pkg::REG_DOT:   cfg_prdata = {16'd0, cfg_r.dot_ticks};
      mlk_pkg::REG_DASH:  cfg_prdata = {16'd0, cfg_r.dash_ticks};
      mlk_pkg::REG_EGAP:  cfg_prdata = {16'd0, cfg_r.element_gap_ticks};
      mlk_pkg::REG_LGAP:  cfg_prdata = {16'd0, cfg_r.letter_gap_ticks};
      mlk_pkg::REG_WLEN:  cfg_prdata = {27'd0, cfg_r.word_length};
      mlk_pkg::REG_FRAME: cfg_prdata = {16'd0, cfg_r.frame_period_ticks};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  mlk_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  mlk_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  mlk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a lit led only occurs during playback
  `MLK_ASSERT_IMP(a_led_playing, clk, rst_n, out_tvalid && out_tdata[0], out_tdata[1])
  // a stalled input side means the queue holds work
  `MLK_ASSERT_IMP(a_stall_has_work, clk, rst_n, !in_tready, q_valid)
  // an input beat into an empty pipe comes out through the queue and the output register
  `MLK_ASSERT_NXT(a_latency, clk, rst_n, in_tvalid && in_tready && !q_valid && !out_tvalid,
                  ##1 out_tvalid)

endmodule

@@ bench/keyer_led_checker.sv @@
`timescale 1ns / 1ps

module keyer_led_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        in_tuser,     // [0] req_type
  input  logic [7:0]  in_tdata,     // [7:0] char_code
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,    // [0] led_on, [1] playing, [7:2] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatch_count,
  output int          pending_results
);

  typedef enum logic [2:0] {
    KEY_IDLE, KEY_SCAN, KEY_MARK, KEY_SPACE, KEY_LETTER_GAP
  } key_state_t;

  typedef struct packed {
    logic led_on;
    logic playing;
  } led_state_t;

  typedef struct packed {
    logic [2:0] elements;
    logic [7:0] dashes;   // bit i set: element i is a dash
  } morse_code_t;

  logic [15:0] dot_len, dash_len, space_len, letter_len, frame_len;
  logic [4:0]  word_len;

  key_state_t  key_state;
  logic [15:0] elem_timer, frame_timer;
  logic [7:0]  char_buf [mlk_pkg::BUF_DEPTH];
  logic [4:0]  char_cnt, play_pos;
  logic [2:0]  elem_pos;
  logic        led;

  led_state_t  expected_leds [$];

  function automatic morse_code_t morse_of(input logic [7:0] c);
    morse_code_t m;
    m = '0;
    case (c)
      "T", "t": begin
        m.elements = 3'd1;
        m.dashes   = 8'h01;
      end
      "E", "e": m.elements = 3'd1;
      "S", "s": m.elements = 3'd3;
      "3": begin
        m.elements = 3'd5;
        m.dashes   = 8'h18;
      end
      default: ;
    endcase
    return m;
  endfunction

  // one millisecond tick of the keyer
  function void advance_keyer();
    morse_code_t code;
    logic [15:0] on_len;
    if (frame_timer != 16'hFFFF) frame_timer++;
    case (key_state)
      KEY_SCAN: begin
        if (play_pos < char_cnt) begin
          code = morse_of(char_buf[play_pos]);
          elem_pos = '0;
          if (code.elements != 3'd0) begin
            led = 1'b1;
            elem_timer = '0;
            key_state = KEY_MARK;
          end else begin
            // unknown character, skipped with no gap
            play_pos++;
          end
        end else begin
          key_state = KEY_IDLE;
        end
      end
      KEY_MARK: begin
        code = morse_of(char_buf[play_pos]);
        on_len = code.dashes[elem_pos] ? dash_len : dot_len;
        if (elem_timer != 16'hFFFF) elem_timer++;
        if (elem_timer >= on_len) begin
          led = 1'b0;
          elem_timer = '0;
          key_state = KEY_SPACE;
        end
      end
      KEY_SPACE: begin
        if (elem_timer != 16'hFFFF) elem_timer++;
        if (elem_timer >= space_len) begin
          code = morse_of(char_buf[play_pos]);
          elem_pos = elem_pos + 3'd1;
          elem_timer = '0;
          if (elem_pos < code.elements) begin
            led = 1'b1;
            key_state = KEY_MARK;
          end else begin
            play_pos++;
            key_state = KEY_LETTER_GAP;
          end
        end
      end
      KEY_LETTER_GAP: begin
        if (elem_timer != 16'hFFFF) elem_timer++;
        if (elem_timer >= letter_len) key_state = KEY_SCAN;
      end
      default: begin
        key_state = KEY_IDLE;
        if (frame_timer >= frame_len) begin
          frame_timer = '0;
          char_cnt = '0;
          play_pos = '0;
        end else if (char_cnt >= word_len && play_pos == '0) begin
          key_state = KEY_SCAN;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    led_state_t got, want;
    if (!rst_n) begin
      dot_len = 16'd25;
      dash_len = 16'd75;
      space_len = 16'd30;
      letter_len = 16'd100;
      word_len = 5'd5;
      frame_len = 16'd2000;
      key_state = KEY_IDLE;
      elem_timer = '0;
      frame_timer = '0;
      char_cnt = '0;
      play_pos = '0;
      elem_pos = '0;
      led = 1'b0;
      expected_leds.delete();
      mismatch_count = 0;
      pending_results = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          mlk_pkg::REG_DOT:   dot_len = cfg_pwdata[15:0];
          mlk_pkg::REG_DASH:  dash_len = cfg_pwdata[15:0];
          mlk_pkg::REG_EGAP:  space_len = cfg_pwdata[15:0];
          mlk_pkg::REG_LGAP:  letter_len = cfg_pwdata[15:0];
          mlk_pkg::REG_WLEN:  word_len = cfg_pwdata[4:0];
          mlk_pkg::REG_FRAME: frame_len = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          // one slot stays unused, a character beyond that is dropped
          if (char_cnt < mlk_pkg::BUF_DEPTH - 1) begin
            char_buf[char_cnt] = in_tdata;
            char_cnt++;
          end
        end else begin
          advance_keyer();
        end
        expected_leds.push_back(led_state_t'{led, key_state != KEY_IDLE});
      end
      if (out_tvalid && out_tready) begin
        got.led_on = out_tdata[0];
        got.playing = out_tdata[1];
        if (expected_leds.size() == 0) begin
          $display("%0t: result beat led_on=%0b playing=%0b, expected none",
                   $time, got.led_on, got.playing);
          mismatch_count++;
        end else begin
          want = expected_leds.pop_front();
          if (got.led_on !== want.led_on) begin
            $display("%0t: led_on expected %0b actual %0b", $time, want.led_on, got.led_on);
            mismatch_count++;
          end
          if (got.playing !== want.playing) begin
            $display("%0t: playing expected %0b actual %0b",
                     $time, want.playing, got.playing);
            mismatch_count++;
          end
        end
      end
      pending_results = expected_leds.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 50;
  // addresses past the last register, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic        in_tuser;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatch_count;
  int pending_results;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int word_len_now = 5;

  morse_led_keyer_top dut (.*);

  keyer_led_checker u_led_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // in_tvalid is left high so back-to-back beats need no drop
  task automatic send_beat(input logic is_char, input logic [7:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= is_char;
    in_tdata <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  // psel and penable stay high, the next write drops penable and load_timing drops both
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic load_timing(input logic [15:0] dot, input logic [15:0] dash,
                             input logic [15:0] egap, input logic [15:0] lgap,
                             input logic [4:0] wlen, input logic [15:0] frame);
    write_reg(mlk_pkg::REG_DOT, {16'd0, dot});
    write_reg(mlk_pkg::REG_DASH, {16'd0, dash});
    write_reg(mlk_pkg::REG_EGAP, {16'd0, egap});
    write_reg(mlk_pkg::REG_LGAP, {16'd0, lgap});
    write_reg(mlk_pkg::REG_WLEN, {27'd0, wlen});
    write_reg(mlk_pkg::REG_FRAME, {16'd0, frame});
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    word_len_now = wlen;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] opening_chars [9];
    logic [7:0] known [7];
    logic [7:0] code;
    logic       run_chars;
    int         run_left;

    opening_chars = '{"T", "e", 8'hFF, "3", "S", 8'h00, "t", "E", "s"};
    known = '{"T", "t", "E", "e", "S", "s", "3"};
    in_tvalid <= 1'b0;
    in_tuser <= 1'b0;
    in_tdata <= 8'd0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero dot and gap times end their phase on the first tick
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    load_timing(16'd0, 16'd1, 16'd0, 16'd0, 5'd2, 16'd40);
    foreach (opening_chars[i]) send_beat(1'b1, opening_chars[i]);
    repeat (6) send_beat(1'b0, 8'($urandom));
    // characters that land while a word is playing
    send_beat(1'b1, "E");
    send_beat(1'b1, 8'h80);
    repeat (6) send_beat(1'b0, 8'($urandom));
    drain_results();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_timing(16'd25, 16'd75, 16'd30, 16'd100, 5'd5, 16'd2000);
        1: load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd19, 16'hFFFF);
        2: load_timing(16'd1, 16'd1, 16'd1, 16'd1, 5'd1, 16'd1);
        3: load_timing(16'd0, 16'd0, 16'd0, 16'd0, 5'd0, 16'd0);
        default: load_timing(16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                             16'($urandom_range(1, 3)), 16'($urandom_range(1, 5)),
                             5'($urandom_range(1, 19)), 16'($urandom_range(20, 150)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      run_left = 0;
      run_chars = 1'b0;
      // bursts of characters, up to one more than a word length, mixed at random with runs of ticks
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (run_left == 0) begin
          run_chars = ($urandom_range(99) < 40);
          run_left = run_chars ? $urandom_range(1, word_len_now + 1) : $urandom_range(1, 40);
        end
        run_left--;
        if (run_chars && $urandom_range(99) < 75) code = known[3'($urandom_range(6))];
        else code = 8'($urandom);
        send_beat(run_chars ^ ($urandom_range(99) < 5), code);
        if (p == 5 && n == PHASE_BEATS / 2) drain_results();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
